[rtl/rpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rpg_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_DRAW,
    ST_MIX,
    ST_MOD,
    ST_READ,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_OUT
  } rpg_state_t;

  localparam logic [63:0] DEFAULT_SEED = 64'h464F_4C44_5345_4544;
  localparam logic [63:0] GOLDEN_INC   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned SHIFT_PRE  = 30;
  localparam int unsigned SHIFT_MID  = 27;
  localparam int unsigned SHIFT_POST = 31;

  // multiply sequence: low x low, low x high, high x low, final add
  localparam logic [1:0] PH_LL  = 2'd0;
  localparam logic [1:0] PH_LH  = 2'd1;
  localparam logic [1:0] PH_HL  = 2'd2;
  localparam logic [1:0] PH_SUM = 2'd3;

  // remainder unit: 8 dividend bits per cycle
  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MOD_STEPS = 64 / MOD_BITS;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic REG_SEED = 1'b0;

endpackage

`default_nettype wire

[rtl/random_permutation_generator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Random permutation generator (Fisher-Yates shuffle, splitmix64 draws).
// Command channel: pulse start with length while busy is low. A length of 0
// is dropped; lengths above MAX_LENGTH saturate. Each permutation entry comes
// out on element for one cycle with strobe high, index zero first; last
// marks the final entry. The receiver cannot stall the block.
// Sequence for length n: n fill writes, then n-1 shuffle steps (each: 1 add,
// two passes on one shared 32x32 multiplier, the remainder unit at 8 bits
// per cycle, 1 read, 2 writes on the store), then n output reads. A new
// item is not accepted until the output reads are done and busy is low.
// Seed register at paddr 0 (64-bit); writing it reloads the generator,
// zero selects the built-in default. The generator state carries over
// between items. Reset loads the default seed and idles; the permutation
// store needs no clearing since every item fills it before use.
module random_permutation_generator #(
  parameter int unsigned MAX_LENGTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [$clog2(MAX_LENGTH+1)-1:0]  length,
  output logic                                  strobe,
  output logic      [$clog2(MAX_LENGTH)-1:0]    element,
  output logic                                  last,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [3:0]                       paddr,
  input  wire logic [63:0]                      pwdata,
  output logic      [63:0]                      prdata,
  output logic                                  pready
);
  import rpg_pkg::*;

  localparam int unsigned EW = $clog2(MAX_LENGTH);
  localparam int unsigned LW = $clog2(MAX_LENGTH + 1);

  rpg_state_t state, state_next;

  logic [63:0] seed;
  logic [63:0] rng;
  logic [LW-1:0] n_len;
  logic [LW-1:0] cnt;
  logic [LW-1:0] cnt_dec;
  logic [LW-1:0] n_last;
  logic [LW-1:0] len_sat;

  logic [1:0]  ph;
  logic        pass;
  logic [63:0] mul_a;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_b;
  logic [63:0] mix_sum;
  logic [63:0] rng_inc;

  logic [63:0]          rnd;
  logic [LW-1:0]        rem;
  logic [LW-1:0]        rem_new;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [EW-1:0]        j_idx;

  logic [EW-1:0] mem [MAX_LENGTH];
  logic          mem_we;
  logic [EW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          rd_en;
  logic [EW-1:0] rd_addr_a;
  logic [EW-1:0] rd_addr_b;
  logic [EW-1:0] rd_a;
  logic [EW-1:0] rd_b;

  logic accept;
  logic cfg_wr;
  logic fill_end;
  logic out_end;

  assign len_sat  = (length > LW'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : length;
  assign accept   = start && !busy && (len_sat != '0);
  assign cnt_dec  = cnt - LW'(1);
  assign n_last   = n_len - LW'(1);
  assign fill_end = (cnt == n_last);
  assign out_end  = (cnt == n_last);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[3] == REG_SEED) ? seed : '0;

  assign rng_inc = rng + GOLDEN_INC;
  assign mul_b   = pass ? MIX_MUL_B : MIX_MUL_A;
  assign mul_x   = (ph == PH_HL) ? mul_a[63:32] : mul_a[31:0];
  assign mul_y   = (ph == PH_LH) ? mul_b[63:32] : mul_b[31:0];
  assign mix_sum = acc + {prod[31:0], 32'b0};

  always_comb begin
    logic [LW:0]   t;
    logic [LW-1:0] r;
    r = rem;
    for (int k = 0; k < MOD_BITS; k++) begin
      t = {r, rnd[63-k]};
      if (t >= {1'b0, cnt}) begin
        t = t - {1'b0, cnt};
      end
      r = t[LW-1:0];
    end
    rem_new = r;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_FILL;
      ST_FILL:   if (fill_end) state_next = (n_len == LW'(1)) ? ST_OUT : ST_DRAW;
      ST_DRAW:   state_next = ST_MIX;
      ST_MIX:    if (ph == PH_SUM && pass) state_next = ST_MOD;
      ST_MOD:    if (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1)) state_next = ST_READ;
      ST_READ:   state_next = ST_SWAP_A;
      ST_SWAP_A: state_next = ST_SWAP_B;
      ST_SWAP_B: state_next = (cnt_dec == LW'(1)) ? ST_OUT : ST_DRAW;
      ST_OUT:    if (out_end) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = cnt[EW-1:0];
    mem_wdata = cnt[EW-1:0];
    rd_en     = 1'b0;
    rd_addr_a = cnt_dec[EW-1:0];
    rd_addr_b = j_idx;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_FILL: mem_we = 1'b1;
      ST_READ: rd_en = 1'b1;
      ST_SWAP_A: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_dec[EW-1:0];
        mem_wdata = rd_b;
      end
      ST_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = j_idx;
        mem_wdata = rd_a;
      end
      ST_OUT: begin
        rd_en     = 1'b1;
        rd_addr_a = cnt[EW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      seed   <= '0;
      rng    <= DEFAULT_SEED;
      strobe <= 1'b0;
      last   <= 1'b0;
      cnt    <= '0;
      n_len  <= '0;
      ph     <= PH_LL;
      pass   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_OUT);
      last   <= (state == ST_OUT) && out_end;
      if (cfg_wr && paddr[3] == REG_SEED) begin
        seed <= pwdata;
        rng  <= (pwdata == '0) ? DEFAULT_SEED : pwdata;
      end
      case (state)
        ST_IDLE: begin
          cnt   <= '0;
          n_len <= len_sat;
        end
        ST_FILL: cnt <= fill_end ? ((n_len == LW'(1)) ? '0 : n_len) : cnt + LW'(1);
        ST_DRAW: begin
          rng  <= rng_inc;
          ph   <= PH_LL;
          pass <= 1'b0;
        end
        ST_MIX: begin
          ph <= ph + 2'd1;
          if (ph == PH_SUM) begin
            pass <= 1'b1;
          end
        end
        ST_SWAP_B: cnt <= (cnt_dec == LW'(1)) ? '0 : cnt_dec;
        ST_OUT: if (!out_end) cnt <= cnt + LW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_DRAW: mul_a <= rng_inc ^ (rng_inc >> SHIFT_PRE);
      ST_MIX: begin
        prod <= 64'(mul_x) * 64'(mul_y);
        case (ph)
          PH_LH:  acc <= prod;
          PH_HL:  acc <= mix_sum;
          PH_SUM: begin
            if (pass) begin
              rnd     <= mix_sum ^ (mix_sum >> SHIFT_POST);
              rem     <= '0;
              mod_cnt <= '0;
            end else begin
              mul_a <= mix_sum ^ (mix_sum >> SHIFT_MID);
            end
          end
          default: ;
        endcase
      end
      ST_MOD: begin
        rem     <= rem_new;
        rnd     <= rnd << MOD_BITS;
        mod_cnt <= mod_cnt + MOD_CNT_W'(1);
        j_idx   <= rem_new[EW-1:0];
      end
      default: ;
    endcase
  end

  assign element = rd_a;

  ap_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final element while still busy");

  ap_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside an output burst");

  ap_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy && length != '0 |=> busy && !strobe)
    else $error("item accepted but block not busy");

  ap_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe)
    else $error("element strobed while idle");

endmodule

`default_nettype wire

[test/tb_random_permutation_generator.sv]
`timescale 1ns / 1ps

module tb_random_permutation_generator;
  import rpg_pkg::*;

  localparam int unsigned PERM_MAX = 16;
  localparam logic [3:0] SEED_ADDR = 4'(REG_SEED) * 4'd8;
  localparam logic [3:0] UNMAPPED_ADDR = 4'd8;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [3:0] element;
    logic       last;
  } perm_entry_t;

  class shuffle_scoreboard;
    logic [63:0] gen_state;
    perm_entry_t entries_due[$];
    int errors;

    function new();
      errors = 0;
      load_seed(64'd0);
    endfunction

    function void load_seed(logic [63:0] value);
      gen_state = (value == 64'd0) ? DEFAULT_SEED : value;
    endfunction

    function logic [63:0] next_draw();
      logic [63:0] z;
      gen_state = gen_state + GOLDEN_INC;
      z = gen_state;
      z = (z ^ (z >> SHIFT_PRE)) * MIX_MUL_A;
      z = (z ^ (z >> SHIFT_MID)) * MIX_MUL_B;
      return z ^ (z >> SHIFT_POST);
    endfunction

    function void note_request(logic [4:0] len);
      logic [3:0]  order[PERM_MAX];
      logic [3:0]  held;
      logic [63:0] j;
      perm_entry_t ent;
      int n;
      n = (len > PERM_MAX) ? PERM_MAX : int'(len);
      for (int k = 0; k < n; k++) order[k] = 4'(k);
      for (int i = n; i > 1; i--) begin
        j = next_draw() % 64'(i);
        held = order[i-1];
        order[i-1] = order[j];
        order[j] = held;
      end
      for (int k = 0; k < n; k++) begin
        ent.element = order[k];
        ent.last = (k == n - 1);
        entries_due = {entries_due, ent};
      end
    endfunction

    function void check_result(logic [3:0] element, logic last);
      perm_entry_t want;
      if (entries_due.size() == 0) begin
        $display("%0t: unexpected item element=%0d last=%0b", $time, element, last);
        errors++;
        return;
      end
      want = entries_due.pop_front();
      if (element !== want.element) begin
        $display("%0t: element expected %0d actual %0d", $time, want.element, element);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return entries_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [4:0]  length;
  logic        strobe;
  logic [3:0]  element;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  shuffle_scoreboard sb;

  random_permutation_generator #(.MAX_LENGTH(PERM_MAX)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .length(length),
    .strobe(strobe), .element(element), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(element, last);
  end

  task automatic send_request(input logic [4:0] len, input int gap);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    length <= len;
    do @(posedge clk); while (busy);
    sb.note_request(len);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == SEED_ADDR) sb.load_seed(data);
  endtask

  initial begin
    logic [4:0]  directed_lengths[] = '{5'd1, 5'd2, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3,
                                       5'd15, 5'd0, 5'd8, 5'd1, 5'd4, 5'd24, 5'd10,
                                       5'd16, 5'd5};
    logic [63:0] phase_seeds[4];
    int          idle_pct[4] = '{0, 75, 0, 38};
    int          gap;
    int          pick;
    logic [4:0]  len;
    bit          burst;

    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    length <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset seed first, then seed phases: all ones, random, zero (default), random
    foreach (directed_lengths[k]) send_request(directed_lengths[k], 0);

    phase_seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    phase_seeds[1] = {$urandom, $urandom};
    phase_seeds[2] = 64'd0;
    phase_seeds[3] = {$urandom, $urandom};

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(SEED_ADDR, phase_seeds[ph]);
      // writes outside the register map must not touch the generator
      if (ph % 2 == 1) write_reg(UNMAPPED_ADDR, {$urandom, $urandom});
      burst = 1'b0;
      for (int k = 0; k < 76; k++) begin
        if (k % 10 == 0) burst = ($urandom_range(3) == 0);
        pick = $urandom_range(99);
        if (pick < 65) len = 5'($urandom_range(1, 6));
        else if (pick < 85) len = 5'($urandom_range(7, 16));
        else if (pick < 95) len = 5'($urandom_range(17, 31));
        else len = 5'd0;
        gap = 0;
        if (!burst && idle_pct[ph] > 0) begin
          if ($urandom_range(7) == 0) gap = $urandom_range(1, 350);
          else while ($urandom_range(99) < idle_pct[ph]) gap++;
        end
        send_request(len, gap);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rpg_pkg.sv
rtl/random_permutation_generator.sv
test/tb_random_permutation_generator.sv
